/* hw/rtl/ptwt_pkg.sv */
`default_nettype none
package ptwt_pkg;

  localparam int PERIOD_BITS = 31;

  localparam logic [2:0] OP_ADVANCE = 3'd0;
  localparam logic [2:0] OP_GREEDY  = 3'd1;
  localparam logic [2:0] OP_FORCE   = 3'd2;
  localparam logic [2:0] OP_SLIDE   = 3'd3;
  localparam logic [2:0] OP_SET     = 3'd4;

  typedef struct packed {
    logic en;     // consume one bit of every operand
    logic first;  // least significant bit of a pass
    logic sub;    // first adder subtracts
  } alu_ctrl_t;

  typedef struct packed {
    logic lt;     // lhs < rhs over the bits seen so far
    logic le;     // lhs <= rhs over the bits seen so far
  } alu_flags_t;

endpackage
`default_nettype wire

/* hw/rtl/ptwt_req_if.sv */
`default_nettype none
interface ptwt_req_if #(
  parameter int TICK_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           opcode;
  logic [TICK_BITS-1:0] tick_value;

  modport source (output valid, output opcode, output tick_value, input ready);
  modport sink   (input valid, input opcode, input tick_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ptwt_rsp_if.sv */
`default_nettype none
interface ptwt_rsp_if #(
  parameter int TICK_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 changed;
  logic [TICK_BITS-1:0] window_start;
  logic [TICK_BITS-1:0] window_end;

  modport source (output valid, output changed, output window_start, output window_end,
                  input ready);
  modport sink   (input valid, input changed, input window_start, input window_end,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/ptwt_cfg_if.sv */
`default_nettype none
interface ptwt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ptwt_pkg::PERIOD_BITS-1:0] window_period;

  modport source (output valid, output window_period, input ready);
  modport sink   (input valid, input window_period, output ready);
endinterface
`default_nettype wire

/* hw/rtl/periodic_time_window_tracker.sv */
// Periodic time window tracker.
// Channels: req carries one event (opcode, tick_value); rsp returns one item
// per event (changed, window_start, window_end); cfg writes window_period and
// is always ready. Write cfg only while no event is in flight.
// Ticks pass through a bit-serial adder and compare slice one bit a cycle,
// least significant bit first; one pass walks the window bounds over the full tick width.
// Advance, greedy advance, slide, set start and unknown opcodes run one
// pass, a decide step and a write into the output register; the next event
// is taken once the block is back in idle.
// Force advance, when it moves the window, adds the remainder divider (one
// bit a cycle) and a second serial pass between the decide and write steps.
// One event is worked on at a time; req.ready is high only when idle.
// The result sits in an output register, so a new event is accepted while
// rsp waits; if rsp is still stalled when the next result is done, the block
// holds that result until the output register frees.
// Reset (rst, synchronous) gives the window [0, 1) and a period of one,
// empties the output register and needs no clearing pass.
`default_nettype none
module periodic_time_window_tracker #(
  parameter int TICK_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  ptwt_cfg_if.sink  cfg,
  ptwt_req_if.sink  req,
  ptwt_rsp_if.source rsp
);

  localparam int W        = TICK_BITS;
  localparam int PB       = ptwt_pkg::PERIOD_BITS;
  localparam int CNT_BITS = $clog2(W);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(W - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PASS1  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_PASS2  = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;

  logic [2:0]          state, state_next;
  logic [CNT_BITS-1:0] cnt;
  logic [PB-1:0]       period;
  logic [PB-1:0]       p_eff;
  logic [W-1:0]        p_wide;
  logic [W-1:0]        start_tick, end_tick;
  logic [W-1:0]        sh_s, sh_e, sh_v, sh_p;
  logic [W-1:0]        sh_r1, sh_r2, sh_r3;
  logic [2:0]          op;
  logic                chg, chg_next;
  logic                out_valid, out_changed;
  logic [W-1:0]        out_start, out_end;
  logic [W-1:0]        new_end;
  logic                accept, pass, load_out, go_div;
  logic                div_start, div_done;
  logic [PB-1:0]       div_rem;
  logic [W+PB-1:0]     p_ext, rem_ext;

  ptwt_pkg::alu_ctrl_t  alu_ctrl;
  ptwt_pkg::alu_flags_t flags;
  logic a1, b1, sub, c2, a3, b3, lhs, rhs;
  logic sum1, sum2, sum3;

  assign p_eff   = (period == '0) ? PB'(1) : period;
  assign p_ext   = {{W{1'b0}}, p_eff};
  assign p_wide  = p_ext[W-1:0];
  assign rem_ext = {{W{1'b0}}, div_rem};

  assign accept   = req.valid && req.ready;
  assign pass     = (state == S_PASS1) || (state == S_PASS2);
  assign load_out = (state == S_WRITE) && (!out_valid || rsp.ready);
  assign go_div   = (op == ptwt_pkg::OP_FORCE) && chg_next;
  assign div_start = (state == S_DECIDE) && go_div;
  assign new_end  = (op == ptwt_pkg::OP_SLIDE) ? sh_r3 : sh_r2;

  assign req.ready        = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign rsp.valid        = out_valid;
  assign rsp.changed      = out_changed;
  assign rsp.window_start = out_start;
  assign rsp.window_end   = out_end;

  // operand routing for one serial bit
  always_comb begin
    a1  = 1'b0;
    b1  = 1'b0;
    sub = 1'b0;
    c2  = 1'b0;
    a3  = 1'b0;
    b3  = 1'b0;
    rhs = sh_v[0];
    case (op)
      ptwt_pkg::OP_ADVANCE, ptwt_pkg::OP_GREEDY: begin
        a1 = sh_s[0];
        b1 = sh_p[0];
        c2 = sh_p[0];
        a3 = sh_e[0];
        b3 = sh_p[0];
      end
      ptwt_pkg::OP_FORCE: begin
        // first pass: span = v - start; second pass: start = v - remainder
        a1  = sh_v[0];
        b1  = sh_s[0];
        sub = 1'b1;
        c2  = sh_p[0];
        rhs = sh_s[0];
      end
      ptwt_pkg::OP_SLIDE: begin
        a1 = sh_s[0];
        b1 = sh_v[0];
        a3 = sh_e[0];
        b3 = sh_v[0];
      end
      ptwt_pkg::OP_SET: begin
        a1 = sh_v[0];
        c2 = sh_p[0];
      end
      default: begin
        a1 = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (op)
      ptwt_pkg::OP_ADVANCE: lhs = sum3;
      ptwt_pkg::OP_GREEDY:  lhs = sh_e[0];
      ptwt_pkg::OP_FORCE:   lhs = sh_v[0];
      default:              lhs = 1'b0;
    endcase
  end

  assign alu_ctrl.en    = pass;
  assign alu_ctrl.first = pass && (cnt == '0);
  assign alu_ctrl.sub   = sub;

  ptwt_serial_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (alu_ctrl),
    .a1    (a1),
    .b1    (b1),
    .c2    (c2),
    .a3    (a3),
    .b3    (b3),
    .lhs   (lhs),
    .rhs   (rhs),
    .sum1  (sum1),
    .sum2  (sum2),
    .sum3  (sum3),
    .flags (flags)
  );

  ptwt_rem_div #(
    .TICK_BITS (W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .span   (sh_r1),
    .period (p_eff),
    .done   (div_done),
    .rem    (div_rem)
  );

  always_comb begin
    case (op)
      ptwt_pkg::OP_ADVANCE: chg_next = flags.le;
      ptwt_pkg::OP_GREEDY:  chg_next = flags.lt;
      ptwt_pkg::OP_FORCE:   chg_next = !flags.lt;
      ptwt_pkg::OP_SLIDE:   chg_next = 1'b1;
      ptwt_pkg::OP_SET:     chg_next = !sh_v[W-1];
      default:              chg_next = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_PASS1;
      S_PASS1:  if (cnt == LAST) state_next = S_DECIDE;
      S_DECIDE: state_next = go_div ? S_DIV : S_WRITE;
      S_DIV:    if (div_done) state_next = S_PASS2;
      S_PASS2:  if (cnt == LAST) state_next = S_WRITE;
      S_WRITE:  if (load_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      period     <= PB'(1);
      start_tick <= '0;
      end_tick   <= W'(1);
      out_valid  <= 1'b0;
      chg        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        period <= cfg.window_period;
      end
      if (accept || (state == S_DIV)) begin
        cnt <= '0;
      end else if (pass) begin
        cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
      end
      if (state == S_DECIDE) begin
        chg <= chg_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        if (chg) begin
          start_tick <= sh_r1;
          end_tick   <= new_end;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= req.opcode;
      sh_s <= start_tick;
      sh_e <= end_tick;
      sh_v <= req.tick_value;
      sh_p <= p_wide;
    end else if (pass) begin
      // operands rotate so they are whole again after a pass
      sh_s  <= {sh_s[0], sh_s[W-1:1]};
      sh_e  <= {sh_e[0], sh_e[W-1:1]};
      sh_v  <= {sh_v[0], sh_v[W-1:1]};
      sh_p  <= {sh_p[0], sh_p[W-1:1]};
      sh_r1 <= {sum1, sh_r1[W-1:1]};
      sh_r2 <= {sum2, sh_r2[W-1:1]};
      sh_r3 <= {sum3, sh_r3[W-1:1]};
    end else if ((state == S_DIV) && div_done) begin
      sh_s <= rem_ext[W-1:0];
    end
    if (load_out) begin
      out_changed <= chg;
      out_start   <= chg ? sh_r1 : start_tick;
      out_end     <= chg ? new_end : end_tick;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("second item accepted while one is in flight");

  a_div_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_pass_end: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PASS1) && (cnt == LAST)) |=> (state == S_DECIDE))
    else $error("serial pass overran the tick width");

  a_slide_moves: assert property (@(posedge clk) disable iff (rst)
    (load_out && (op == ptwt_pkg::OP_SLIDE)) |=> rsp.changed)
    else $error("slide reported no change");

endmodule
`default_nettype wire

/* hw/rtl/ptwt_serial_alu.sv */
`default_nettype none
module ptwt_serial_alu (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ptwt_pkg::alu_ctrl_t  ctrl,
  input  wire logic                 a1,
  input  wire logic                 b1,
  input  wire logic                 c2,
  input  wire logic                 a3,
  input  wire logic                 b3,
  input  wire logic                 lhs,
  input  wire logic                 rhs,
  output logic                      sum1,
  output logic                      sum2,
  output logic                      sum3,
  output ptwt_pkg::alu_flags_t      flags
);

  logic cy1, cy2, cy3, lt, eq;
  logic ci1, ci2, ci3, b1x;
  logic co1, co2, co3, lt_next, eq_next, lt_in, eq_in;

  always_comb begin
    b1x  = b1 ^ ctrl.sub;
    ci1  = ctrl.first ? ctrl.sub : cy1;
    ci2  = ctrl.first ? 1'b0 : cy2;
    ci3  = ctrl.first ? 1'b0 : cy3;
    sum1 = a1 ^ b1x ^ ci1;
    co1  = (a1 & b1x) | (a1 & ci1) | (b1x & ci1);
    // second adder chains on the first sum in the same cycle
    sum2 = sum1 ^ c2 ^ ci2;
    co2  = (sum1 & c2) | (sum1 & ci2) | (c2 & ci2);
    sum3 = a3 ^ b3 ^ ci3;
    co3  = (a3 & b3) | (a3 & ci3) | (b3 & ci3);
    // lsb first compare: a higher differing bit overrides the verdict
    lt_in   = ctrl.first ? 1'b0 : lt;
    eq_in   = ctrl.first ? 1'b1 : eq;
    lt_next = (lhs != rhs) ? (~lhs & rhs) : lt_in;
    eq_next = eq_in & (lhs == rhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cy1 <= 1'b0;
      cy2 <= 1'b0;
      cy3 <= 1'b0;
      lt  <= 1'b0;
      eq  <= 1'b1;
    end else if (ctrl.en) begin
      cy1 <= co1;
      cy2 <= co2;
      cy3 <= co3;
      lt  <= lt_next;
      eq  <= eq_next;
    end
  end

  assign flags.lt = lt;
  assign flags.le = lt | eq;

endmodule
`default_nettype wire

/* hw/rtl/ptwt_rem_div.sv */
`default_nettype none
module ptwt_rem_div #(
  parameter int TICK_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [TICK_BITS-1:0]             span,
  input  wire logic [ptwt_pkg::PERIOD_BITS-1:0] period,
  output logic                                  done,
  output logic [ptwt_pkg::PERIOD_BITS-1:0]      rem
);

  localparam int PB       = ptwt_pkg::PERIOD_BITS;
  localparam int CNT_BITS = $clog2(TICK_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(TICK_BITS - 1);

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [TICK_BITS-1:0] sh;
  logic [PB:0]          trial;
  logic [PB:0]          diff;
  logic                 ge;
  logic [PB-1:0]        rem_next;

  // restoring division, one quotient bit a cycle, only the remainder is kept
  always_comb begin
    trial    = {rem, sh[TICK_BITS-1]};
    diff     = trial - {1'b0, period};
    ge       = trial >= {1'b0, period};
    rem_next = ge ? diff[PB-1:0] : trial[PB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      sh  <= span;
    end else if (busy) begin
      rem <= rem_next;
      sh  <= {sh[TICK_BITS-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire
